@@ rtl/core/assembler_token_lexer_assert.svh @@
// Assertion macros for the assembler token lexer.
// Used inside modules that have a clk and an rst port; no other dependencies.
`ifndef ASSEMBLER_TOKEN_LEXER_ASSERT_SVH
`define ASSEMBLER_TOKEN_LEXER_ASSERT_SVH

// Property checked on every rising clock edge outside of reset.
`define ATL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on the next rising clock edge.
`define ATL_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/core/atl_pkg.sv @@
// Package for the assembler token lexer: token kinds, scan modes, the result
// word layout and the byte classes. No dependencies.
package atl_pkg;

  localparam int POS_BITS = 16;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);

  typedef enum logic [3:0] {
    KIND_INVALID = 4'd0,
    KIND_END     = 4'd1,
    KIND_LPAREN  = 4'd2,
    KIND_RPAREN  = 4'd3,
    KIND_ARROW   = 4'd4,
    KIND_COMMA   = 4'd5,
    KIND_KEYWORD = 4'd6,
    KIND_IDENT   = 4'd7,
    KIND_NUMBER  = 4'd8
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_MINUS  = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic        last;
    logic [15:0] line;
    logic [15:0] length;
    logic [15:0] start;
    token_kind_t kind;
  } token_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [15:0] SAT16      = 16'hFFFF;
  localparam logic [15:0] KW_LEN     = 16'd8;
  localparam logic [7:0]  KW_TEXT [8] = '{8'h66, 8'h75, 8'h6E, 8'h63,
                                          8'h74, 8'h69, 8'h6F, 8'h6E};

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

endpackage

@@ rtl/core/assembler_token_lexer.sv @@
// Top level of the assembler token lexer: byte decode, scan state and a
// four-word result queue. Depends on atl_pkg and assembler_token_lexer_assert.svh.
//
//  channel  dir  tdata / tuser / tlast
//  s_*      in   tdata: text_byte[7:0]; tuser: clear_lines; no tlast
//  m_*      out  tdata: kind, start, length, line; tlast: last_of_run
//
// Each byte is decoded in the cycle it is accepted, one byte per cycle while s_tready is high.
// A byte gives zero, one or two tokens; they go into a four-word queue that
// drives the master side, so a two-token byte fills two queue words.
// s_tready stays high while the queue has room for two words.
// Synchronous reset clears the scan state, counters and the queue.
module assembler_token_lexer
  import atl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic [0:0]  s_tuser,   // [0] clear_lines
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [3:0] token_kind, [19:4] token_start,
                                 // [35:20] token_length, [51:36] token_line
  output logic        m_tlast    // last_of_run
);

  scan_mode_t          mode, mode_next;
  logic                kw_ok, kw_ok_next;
  logic [15:0]         pstart, pstart_next;
  logic [15:0]         plen, plen_next;
  logic [15:0]         pline, pline_next;
  logic [POS_BITS-1:0] pos, pos_next;
  logic [15:0]         line_cnt, line_next;

  token_t              queue [Q_DEPTH];
  logic [Q_AW-1:0]     wr_ptr, rd_ptr;
  logic [Q_CW-1:0]     count;

  logic                s_acc, pop;
  logic [7:0]          c;
  logic                ident_cont, kw_match, kw_done, consumed;
  logic [POS_BITS-1:0] pos_eff;
  logic [15:0]         line_eff, start_eff, plen_inc;
  logic [31:0]         pos_wide;
  token_t              r0, r1;
  logic                v0, v1;
  logic [1:0]          n_push;

  assign s_acc = s_tvalid && s_tready;
  assign pop   = m_tvalid && m_tready;
  assign c     = s_tdata;

  // Clearing takes effect before the byte is looked at.
  assign pos_eff   = s_tuser[0] ? '0 : pos;
  assign line_eff  = s_tuser[0] ? '0 : line_cnt;
  assign pos_wide  = 32'(pos_eff);
  assign start_eff = pos_wide[15:0];

  assign ident_cont = is_letter(c) || is_digit(c) || c == CH_UNDER;
  assign plen_inc   = sat_inc(plen);
  assign kw_match   = kw_ok && plen < KW_LEN && c == KW_TEXT[plen[2:0]];
  assign kw_done    = ident_cont && kw_match && plen_inc == KW_LEN;
  assign consumed   = (mode == MODE_IDENT && ident_cont) ||
                      (mode == MODE_NUMBER && is_digit(c)) ||
                      (mode == MODE_MINUS && c == CH_GT);

  // Next scan state.
  always_comb begin
    mode_next   = mode;
    kw_ok_next  = kw_ok;
    pstart_next = pstart;
    plen_next   = plen;
    pline_next  = pline;
    line_next   = line_eff;
    pos_next    = pos_eff + POS_BITS'(1);
    unique case (mode)
      MODE_IDENT: begin
        if (ident_cont) begin
          plen_next  = plen_inc;
          kw_ok_next = kw_done ? 1'b0 : kw_match;
          if (kw_done) begin
            mode_next = MODE_IDLE;
          end
        end else begin
          mode_next  = MODE_IDLE;
          kw_ok_next = 1'b0;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          plen_next = plen_inc;
        end else begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_MINUS: mode_next = MODE_IDLE;
      default: ;
    endcase
    if (!consumed) begin
      priority if (c == CH_LF) begin
        line_next = sat_inc(line_eff);
      end else if (c == CH_MINUS || is_letter(c) || is_digit(c)) begin
        pstart_next = start_eff;
        plen_next   = 16'd1;
        pline_next  = line_eff;
        if (c == CH_MINUS) begin
          mode_next = MODE_MINUS;
        end else if (is_letter(c)) begin
          mode_next  = MODE_IDENT;
          kw_ok_next = (c == KW_TEXT[0]);
        end else begin
          mode_next = MODE_NUMBER;
        end
      end else begin
      end
    end
  end

  // Tokens caused by the accepted byte: r0 closes a pending token, r1 is
  // the byte's own token.
  always_comb begin
    r0        = '0;
    r1        = '0;
    v0        = 1'b0;
    v1        = 1'b0;
    r0.start  = pstart;
    r0.length = plen;
    r0.line   = pline;
    r0.kind   = KIND_IDENT;
    r1.start  = start_eff;
    r1.length = 16'd1;
    r1.line   = line_eff;
    r1.kind   = KIND_INVALID;
    unique case (mode)
      MODE_IDENT: begin
        if (ident_cont) begin
          v0        = kw_done;
          r0.kind   = KIND_KEYWORD;
          r0.length = KW_LEN;
        end else begin
          v0 = 1'b1;
        end
      end
      MODE_NUMBER: begin
        v0      = !is_digit(c);
        r0.kind = KIND_NUMBER;
      end
      MODE_MINUS: begin
        v0 = 1'b1;
        if (c == CH_GT) begin
          r0.kind   = KIND_ARROW;
          r0.length = 16'd2;
        end else begin
          r0.length = 16'd1;
        end
      end
      default: ;
    endcase
    if (!consumed) begin
      v1 = 1'b1;
      priority if (c == CH_NUL) begin
        r1.kind   = KIND_END;
        r1.length = 16'd0;
      end else if (is_space(c) || c == CH_MINUS || is_letter(c) || is_digit(c)) begin
        v1 = 1'b0;
      end else if (c == CH_LPAR) begin
        r1.kind = KIND_LPAREN;
      end else if (c == CH_RPAR) begin
        r1.kind = KIND_RPAREN;
      end else if (c == CH_COMMA) begin
        r1.kind = KIND_COMMA;
      end else if (c == CH_PLUS || c == CH_STAR || c == CH_SLASH) begin
        r1.kind = KIND_IDENT;
      end else begin
        r1.kind = KIND_INVALID;
      end
    end
    r1.last = v1;
    r0.last = !v1;
    v0      = v0 && s_acc;
    v1      = v1 && s_acc;
  end

  assign n_push = {1'b0, v0} + {1'b0, v1};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      kw_ok    <= 1'b0;
      pstart   <= '0;
      plen     <= '0;
      pline    <= '0;
      pos      <= '0;
      line_cnt <= '0;
    end else if (s_acc) begin
      mode     <= mode_next;
      kw_ok    <= kw_ok_next;
      pstart   <= pstart_next;
      plen     <= plen_next;
      pline    <= pline_next;
      pos      <= pos_next;
      line_cnt <= line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (v0) begin
      queue[wr_ptr] <= r0;
    end
    if (v1) begin
      queue[wr_ptr + Q_AW'(v0)] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_AW'(n_push);
      rd_ptr <= rd_ptr + Q_AW'(pop);
      count  <= count + Q_CW'(n_push) - Q_CW'(pop);
    end
  end

  assign s_tready = count <= Q_CW'(Q_DEPTH - 2);
  assign m_tvalid = count != '0;
  assign m_tdata  = {4'b0000, queue[rd_ptr].line, queue[rd_ptr].length,
                     queue[rd_ptr].start, queue[rd_ptr].kind};
  assign m_tlast  = queue[rd_ptr].last;

`include "assembler_token_lexer_assert.svh"

  `ATL_ASSERT(a_queue_bound, count <= Q_CW'(Q_DEPTH), "result queue overflow")
  `ATL_ASSERT(a_kw_prefix, !kw_ok || (mode == MODE_IDENT && plen < KW_LEN), "stray keyword flag")
  `ATL_ASSERT_NEXT(a_end_token, s_acc && c == CH_NUL, m_tvalid, "zero byte gave no token")
  `ATL_ASSERT_NEXT(a_two_push, n_push == 2'd2 && !pop, count == $past(count) + Q_CW'(2), "word lost")

endmodule

@@ dv/assembler_token_lexer_test.sv @@
// Self-checking testbench for the assembler token lexer: directed text and
// random text, all checked word by word against a behavioral lexer.
// Depends on atl_pkg and the assembler_token_lexer RTL only.
module assembler_token_lexer_test;
  import atl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;

  assembler_token_lexer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioral lexer state.
  scan_mode_t  mode = MODE_IDLE;
  logic        kw_ok = 1'b0;
  logic [15:0] tok_start = '0;
  logic [15:0] tok_len = '0;
  logic [15:0] tok_line = '0;
  logic [15:0] pos = '0;
  logic [15:0] lines = '0;

  token_t      expected_tokens [$];
  token_t      fresh [2];
  int          fresh_n;

  // Values typed into the directed table override the last token of the current byte.
  logic        cur_typed = 1'b0;
  token_kind_t cur_kind = KIND_INVALID;
  logic [15:0] cur_len = '0;

  logic        src_gaps = 1'b0;
  logic        sink_stalls = 1'b0;
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          tokens_checked = 0;
  int          double_bytes = 0;

  typedef struct {
    logic [7:0]  ch;
    logic        clr;
    logic        typed;
    token_kind_t kind;
    logic [15:0] len;
  } script_row_t;

  script_row_t script [26] = '{
    '{CH_LPAR,   1'b1, 1'b1, KIND_LPAREN,  16'd1},
    '{CH_RPAR,   1'b0, 1'b1, KIND_RPAREN,  16'd1},
    '{CH_COMMA,  1'b0, 1'b1, KIND_COMMA,   16'd1},
    '{CH_PLUS,   1'b0, 1'b1, KIND_IDENT,   16'd1},
    '{CH_STAR,   1'b0, 1'b1, KIND_IDENT,   16'd1},
    '{CH_SLASH,  1'b0, 1'b1, KIND_IDENT,   16'd1},
    '{CH_MINUS,  1'b0, 1'b0, KIND_INVALID, 16'd0},
    '{CH_GT,     1'b0, 1'b1, KIND_ARROW,   16'd2},
    '{CH_MINUS,  1'b0, 1'b0, KIND_INVALID, 16'd0},
    '{"5",       1'b0, 1'b1, KIND_IDENT,   16'd1},
    '{CH_LF,     1'b0, 1'b1, KIND_NUMBER,  16'd1},
    '{"f",       1'b0, 1'b0, KIND_INVALID, 16'd0},
    '{"u",       1'b0, 1'b0, KIND_INVALID, 16'd0},
    '{"n",       1'b0, 1'b0, KIND_INVALID, 16'd0},
    '{"c",       1'b0, 1'b0, KIND_INVALID, 16'd0},
    '{"t",       1'b0, 1'b0, KIND_INVALID, 16'd0},
    '{"i",       1'b0, 1'b0, KIND_INVALID, 16'd0},
    '{"o",       1'b0, 1'b0, KIND_INVALID, 16'd0},
    '{"n",       1'b0, 1'b1, KIND_KEYWORD, 16'd8},
    '{"x",       1'b0, 1'b0, KIND_INVALID, 16'd0},
    '{CH_UNDER,  1'b0, 1'b0, KIND_INVALID, 16'd0},
    '{8'hFF,     1'b0, 1'b1, KIND_INVALID, 16'd1},
    '{CH_UNDER,  1'b0, 1'b1, KIND_INVALID, 16'd1},
    '{"9",       1'b0, 1'b0, KIND_INVALID, 16'd0},
    '{"Z",       1'b1, 1'b1, KIND_NUMBER,  16'd1},
    '{CH_NUL,    1'b0, 1'b1, KIND_END,     16'd0}
  };

  function automatic logic letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void add_token(input token_kind_t k, input logic [15:0] s,
                                    input logic [15:0] l, input logic [15:0] ln);
    token_t t;
    t.last = 1'b0;
    t.kind = k;
    t.start = s;
    t.length = l;
    t.line = ln;
    fresh[fresh_n] = t;
    fresh_n++;
  endfunction

  function automatic void open_token(input scan_mode_t m);
    mode = m;
    tok_start = pos;
    tok_len = 16'd1;
    tok_line = lines;
  endfunction

  // Advances the lexer by one byte and queues the tokens that byte produces.
  function automatic void lex_byte(input logic [7:0] c, input logic clr);
    logic consumed;
    consumed = 1'b0;
    fresh_n = 0;
    if (clr) begin
      lines = '0;
      pos = '0;
    end
    case (mode)
      MODE_IDENT: begin
        if (letter(c) || digit(c) || c == CH_UNDER) begin
          kw_ok = kw_ok && tok_len < KW_LEN && c == KW_TEXT[tok_len[2:0]];
          if (tok_len != SAT16) tok_len++;
          if (kw_ok && tok_len == KW_LEN) begin
            add_token(KIND_KEYWORD, tok_start, KW_LEN, tok_line);
            mode = MODE_IDLE;
            kw_ok = 1'b0;
          end
          consumed = 1'b1;
        end else begin
          add_token(KIND_IDENT, tok_start, tok_len, tok_line);
          mode = MODE_IDLE;
          kw_ok = 1'b0;
        end
      end
      MODE_NUMBER: begin
        if (digit(c)) begin
          if (tok_len != SAT16) tok_len++;
          consumed = 1'b1;
        end else begin
          add_token(KIND_NUMBER, tok_start, tok_len, tok_line);
          mode = MODE_IDLE;
        end
      end
      MODE_MINUS: begin
        if (c == CH_GT) begin
          add_token(KIND_ARROW, tok_start, 16'd2, tok_line);
          consumed = 1'b1;
        end else begin
          add_token(KIND_IDENT, tok_start, 16'd1, tok_line);
        end
        mode = MODE_IDLE;
      end
      default: ;
    endcase
    if (!consumed) begin
      if (c == CH_NUL) begin
        add_token(KIND_END, pos, 16'd0, lines);
      end else if (blank(c)) begin
        if (c == CH_LF && lines != SAT16) lines++;
      end else if (c == CH_LPAR) begin
        add_token(KIND_LPAREN, pos, 16'd1, lines);
      end else if (c == CH_RPAR) begin
        add_token(KIND_RPAREN, pos, 16'd1, lines);
      end else if (c == CH_COMMA) begin
        add_token(KIND_COMMA, pos, 16'd1, lines);
      end else if (c == CH_PLUS || c == CH_STAR || c == CH_SLASH) begin
        add_token(KIND_IDENT, pos, 16'd1, lines);
      end else if (c == CH_MINUS) begin
        open_token(MODE_MINUS);
      end else if (letter(c)) begin
        open_token(MODE_IDENT);
        kw_ok = (c == KW_TEXT[0]);
      end else if (digit(c)) begin
        open_token(MODE_NUMBER);
      end else begin
        add_token(KIND_INVALID, pos, 16'd1, lines);
      end
    end
    if (fresh_n > 0) begin
      fresh[fresh_n - 1].last = 1'b1;
      if (cur_typed) begin
        fresh[fresh_n - 1].kind = cur_kind;
        fresh[fresh_n - 1].length = cur_len;
      end
    end
    if (fresh_n == 2) double_bytes++;
    for (int i = 0; i < fresh_n; i++) expected_tokens.push_back(fresh[i]);
    pos = pos + 16'd1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    token_t want;
    if (rst) begin
      mode = MODE_IDLE;
      kw_ok = 1'b0;
      tok_start = '0;
      tok_len = '0;
      tok_line = '0;
      pos = '0;
      lines = '0;
    end else begin
      if (s_tvalid && s_tready) lex_byte(s_tdata, s_tuser[0]);
      if (m_tvalid && m_tready) begin
        if (expected_tokens.size() == 0) begin
          $error("token word %h arrived with none expected", m_tdata);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", 16'(want.kind), 16'(m_tdata[3:0]));
          check_field("token_start", want.start, m_tdata[19:4]);
          check_field("token_length", want.length, m_tdata[35:20]);
          check_field("token_line", want.line, m_tdata[51:36]);
          check_field("last_of_run", 16'(want.last), 16'(m_tlast));
          tokens_checked++;
        end
      end
    end
  end

  // Result side: a fresh stall is drawn for every word taken.
  initial begin : sink
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = sink_stalls ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Presents one byte after an optional gap and returns at the edge that accepts it.
  task automatic push_byte(input logic [7:0] b, input logic clr, input logic typed,
                           input token_kind_t kind, input logic [15:0] len);
    int gap;
    gap = src_gaps ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_typed = typed;
    cur_kind = kind;
    cur_len = len;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= clr;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic push_text(input logic [7:0] b);
    push_byte(b, $urandom_range(0, 49) == 0, 1'b0, KIND_INVALID, 16'd0);
  endtask

  task automatic drain_tokens();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  // One lexeme of plausible assembler text; neighbors run together on purpose.
  task automatic send_lexeme();
    int pick;
    int n;
    int r;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) push_text(KW_TEXT[i]);
      end else begin
        push_text(rand_letter());
      end
      repeat ($urandom_range(0, 10)) begin
        r = $urandom_range(0, 62);
        if (r < 52) push_text(rand_letter());
        else if (r < 62) push_text(8'("0" + r - 52));
        else push_text(CH_UNDER);
      end
    end else if (pick < 45) begin
      repeat ($urandom_range(1, 6)) push_text(8'("0" + $urandom_range(0, 9)));
    end else if (pick < 60) begin
      case ($urandom_range(0, 5))
        0: push_text(CH_LPAR);
        1: push_text(CH_RPAR);
        2: push_text(CH_COMMA);
        3: push_text(CH_PLUS);
        4: push_text(CH_STAR);
        default: push_text(CH_SLASH);
      endcase
    end else if (pick < 65) begin
      push_text(CH_MINUS);
      push_text(CH_GT);
    end else if (pick < 70) begin
      push_text(CH_MINUS);
    end else if (pick < 85) begin
      r = $urandom_range(8, 13);
      push_text(r == 8 ? 8'h20 : 8'(r));
    end else if (pick < 93) begin
      do c = 8'($urandom_range(1, 255));
      while (letter(c) || digit(c) || blank(c) ||
             c inside {CH_LPAR, CH_RPAR, CH_COMMA, CH_PLUS, CH_STAR, CH_SLASH, CH_MINUS});
      push_text(c);
    end else if (pick < 97) begin
      push_text(8'($urandom_range(0, 255)));
    end else begin
      push_text(CH_NUL);
    end
  endtask

  initial begin : stimulus
    int mark;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 26; i++)
      push_byte(script[i].ch, script[i].clr, script[i].typed, script[i].kind, script[i].len);
    drain_tokens();

    for (int blk = 0; blk < 14; blk++) begin
      src_gaps = (blk != 0) && ($urandom_range(0, 3) != 0);
      sink_stalls = (blk != 0) && ($urandom_range(0, 3) != 0);
      if (blk == 7) drain_tokens();
      mark = bytes_sent;
      while (bytes_sent < mark + 64) send_lexeme();
    end
    push_text(CH_NUL);

    drain_tokens();
    repeat (16) @(posedge clk);
    $display("Run covered %0d text bytes and %0d checked tokens, %0d bytes gave two tokens.",
             bytes_sent, tokens_checked, double_bytes);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/atl_pkg.sv
rtl/core/assembler_token_lexer.sv
dv/assembler_token_lexer_test.sv
